// ===== design/gcva_pkg.sv =====
package gcva_pkg;

    localparam int MAP_WIDTH  = 64;
    localparam int MAP_HEIGHT = 64;
    localparam int XW         = 6;
    localparam int YW         = 6;
    localparam int AW         = XW + YW;
    localparam int SUM_W      = 40;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [3:0] WEIGHT_OFFSET = 4'd5;
    localparam int NUM_W      = 46;
    localparam int DEN_W      = 25;
    localparam int QUO_W      = 22;

    typedef enum logic [2:0] {
        CMD_CLEAR  = 3'd0,
        CMD_WRITE  = 3'd1,
        CMD_VOTE   = 3'd2,
        CMD_MAX    = 3'd3,
        CMD_READ   = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        REG_LEFT   = 3'd0,
        REG_TOP    = 3'd1,
        REG_WIDTH  = 3'd2,
        REG_HEIGHT = 3'd3,
        REG_WEN    = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_V_CALC,
        ST_V_MUL,
        ST_V_DIV,
        ST_V_WGT,
        ST_V_ACC,
        ST_V_NEXT,
        ST_M_RD,
        ST_M_CMP,
        ST_R_RD,
        ST_R_OUT,
        ST_OUT,
        ST_INIT
    } state_t;

endpackage

// ===== design/gcva_div.sv =====
module gcva_div
    import gcva_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [QUO_W-1:0] quo
);

    logic [NUM_W-1:0] q_reg;
    logic [DEN_W:0]   r_reg;
    logic [DEN_W-1:0] d_reg;
    logic [5:0]       cnt_reg;
    logic [DEN_W:0]   r_sh;
    logic [DEN_W:0]   r_sub;

    assign r_sh  = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};
    assign r_sub = r_sh - {1'b0, d_reg};
    assign busy  = (cnt_reg != 6'd0);
    assign quo   = q_reg[QUO_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= 6'(NUM_W);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy)
        begin
            if (!r_sub[DEN_W])
            begin
                r_reg <= r_sub;
                q_reg <= {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= r_sh;
                q_reg <= {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

endmodule

// ===== design/gradient_center_vote_accumulator.sv =====
// Eye-center voting map of 64x64 40-bit sums with an 8-bit weight image.
// One beat in, one beat out per command. After reset the map is swept to zero
// before the first beat is taken. Clear sweeps the map; report maximum reads
// every entry. A vote visits every candidate in the area, one at a time,
// through a multiply step and a shared 46-step restoring divider; a skipped
// candidate bypasses the divider.
module gradient_center_vote_accumulator
    import gcva_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [2:0]              cfg_index,
    input  logic [6:0]              cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [2:0]              command,
    input  logic [5:0]              pos_x,
    input  logic [5:0]              pos_y,
    input  logic signed [15:0]      grad_x,
    input  logic signed [15:0]      grad_y,
    input  logic [7:0]              weight_value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [5:0]              result_x,
    output logic [5:0]              result_y,
    output logic [SUM_W-1:0]        vote_sum,
    output logic                    saturated
);

    logic [SUM_W-1:0] vmem [MAP_WIDTH*MAP_HEIGHT];
    logic [7:0]       wmem [MAP_WIDTH*MAP_HEIGHT];

    logic [5:0] left_reg, top_reg;
    logic [6:0] width_reg, height_reg;
    logic       wen_reg;

    state_t state_reg, state_next;
    logic [2:0]  cmd_reg;
    logic [5:0]  ox_reg, oy_reg;
    logic signed [15:0] gx_reg, gy_reg;
    logic [XW-1:0] cx_reg, cx_next;
    logic [YW-1:0] cy_reg, cy_next;
    logic [XW:0]   x_end, y_end;
    logic [AW-1:0] caddr;
    logic          cfg_ok;

    logic signed [23:0] dot_reg;
    logic [12:0]        dd_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [DEN_W-1:0]   den_reg;
    logic               skip_reg;
    logic [SUM_W-1:0]   vrd_reg;
    logic [7:0]         wrd_reg;
    logic [SUM_W-1:0]   term_reg;
    logic               sat_reg;

    logic [AW-1:0]      best_reg;
    logic [SUM_W-1:0]   bestv_reg;

    logic [5:0]         rx_reg, ry_reg;
    logic [SUM_W-1:0]   rs_reg;
    logic               rsat_reg;
    logic               ov_reg;

    logic               div_start, div_busy;
    logic [QUO_W-1:0]   quo;
    logic [SUM_W:0]     acc;

    logic signed [6:0] dx_next, dy_next;

    logic [XW+1:0] xe_full;
    logic [YW+1:0] ye_full;
    assign xe_full = {2'b0, left_reg} + {1'b0, width_reg};
    assign ye_full = {2'b0, top_reg} + {1'b0, height_reg};
    assign x_end = (xe_full > (XW+2)'(MAP_WIDTH)) ? (XW+1)'(MAP_WIDTH) : xe_full[XW:0];
    assign y_end = (ye_full > (YW+2)'(MAP_HEIGHT)) ? (YW+1)'(MAP_HEIGHT) : ye_full[YW:0];
    assign caddr = {cy_reg, cx_reg};

    assign in_ready  = (state_reg == ST_IDLE) && !ov_reg;
    assign cfg_ready = in_ready;
    assign cfg_ok    = cfg_valid && cfg_ready;
    assign out_valid = ov_reg;
    assign result_x  = rx_reg;
    assign result_y  = ry_reg;
    assign vote_sum  = rs_reg;
    assign saturated = rsat_reg;
    assign acc = {1'b0, vrd_reg} + {1'b0, term_reg};

    assign dx_next = $signed({1'b0, ox_reg}) - $signed({1'b0, cx_reg});
    assign dy_next = $signed({1'b0, oy_reg}) - $signed({1'b0, cy_reg});

    gcva_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .busy  (div_busy),
        .quo   (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0; top_reg <= '0;
            width_reg <= 7'd64; height_reg <= 7'd64; wen_reg <= 1'b1;
        end
        else if (cfg_ok)
        begin
            case (cfg_index)
                REG_LEFT:   left_reg   <= cfg_data[5:0];
                REG_TOP:    top_reg    <= cfg_data[5:0];
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_WEN:    wen_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic cand_last_x, cand_last_y;
    assign cand_last_x = ({1'b0, cx_reg} + 1'b1) >= x_end;
    assign cand_last_y = ({1'b0, cy_reg} + 1'b1) >= y_end;
    logic empty_area;
    assign empty_area = ({1'b0, left_reg} >= x_end) || ({1'b0, top_reg} >= y_end);

    always_comb
    begin
        state_next = state_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        div_start = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    case (command)
                        CMD_CLEAR:
                        begin
                            state_next = ST_CLEAR; cx_next = '0; cy_next = '0;
                        end
                        CMD_VOTE:
                        begin
                            state_next = empty_area ? ST_OUT : ST_V_CALC;
                            cx_next = left_reg; cy_next = top_reg;
                        end
                        CMD_MAX:
                        begin
                            state_next = ST_M_RD; cx_next = '0; cy_next = '0;
                        end
                        CMD_READ:
                        begin
                            state_next = ST_R_RD; cx_next = pos_x; cy_next = pos_y;
                        end
                        default: state_next = ST_OUT;
                    endcase
                end
            end
            ST_INIT:
            begin
                {cy_next, cx_next} = caddr + 1'b1;
                if (&caddr) state_next = ST_IDLE;
            end
            ST_CLEAR:
            begin
                {cy_next, cx_next} = caddr + 1'b1;
                if (&caddr) state_next = ST_OUT;
            end
            ST_V_CALC: state_next = ST_V_MUL;
            ST_V_MUL:  state_next = (skip_reg || dot_reg <= 24'sd0) ? ST_V_NEXT : ST_V_DIV;
            ST_V_DIV:
            begin
                if (!div_busy && !skip_reg) div_start = 1'b1;
                if (div_busy) state_next = ST_V_DIV;
                else if (skip_reg) state_next = ST_V_WGT;
            end
            ST_V_WGT:  state_next = ST_V_ACC;
            ST_V_ACC:  state_next = ST_V_NEXT;
            ST_V_NEXT:
            begin
                if (cand_last_x)
                begin
                    cx_next = left_reg;
                    cy_next = cy_reg + 1'b1;
                    state_next = cand_last_y ? ST_OUT : ST_V_CALC;
                end
                else
                begin
                    cx_next = cx_reg + 1'b1;
                    state_next = ST_V_CALC;
                end
            end
            ST_M_RD:  state_next = ST_M_CMP;
            ST_M_CMP:
            begin
                {cy_next, cx_next} = caddr + 1'b1;
                state_next = (&caddr) ? ST_OUT : ST_M_RD;
            end
            ST_R_RD:  state_next = ST_R_OUT;
            ST_R_OUT: state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // skip_reg doubles as "divider launched" flag in ST_V_DIV
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            cx_reg    <= '0;
            cy_reg    <= '0;
            ov_reg    <= 1'b0;
            sat_reg   <= 1'b0;
            skip_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            if (out_valid && out_ready) ov_reg <= 1'b0;
            if (state_reg == ST_OUT) ov_reg <= 1'b1;
            if (in_valid && in_ready) sat_reg <= 1'b0;
            if (state_reg == ST_V_ACC && acc[SUM_W]) sat_reg <= 1'b1;
            if (state_reg == ST_V_CALC)
                skip_reg <= (dx_next == 7'sd0) && (dy_next == 7'sd0);
            else if (state_reg == ST_V_MUL)
                skip_reg <= skip_reg || (dot_reg <= 24'sd0);
            else if (state_reg == ST_V_DIV)
                skip_reg <= div_start ? 1'b1 : skip_reg;
            else if (state_reg == ST_V_WGT)
                skip_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= command;
            ox_reg <= pos_x; oy_reg <= pos_y;
            gx_reg <= grad_x; gy_reg <= grad_y;
            best_reg <= '0;
            bestv_reg <= '0;
        end
        case (state_reg)
            ST_V_CALC:
            begin
                dot_reg <= 24'(dx_next * gx_reg) + 24'(dy_next * gy_reg);
                dd_reg <= 13'(dx_next * dx_next) + 13'(dy_next * dy_next);
                vrd_reg <= vmem[caddr];
                wrd_reg <= wmem[caddr];
            end
            ST_V_MUL:
            begin
                num_reg <= NUM_W'(dot_reg * dot_reg);
                den_reg <= {dd_reg, 12'd0};
            end
            ST_V_WGT:
            begin
                if (wen_reg)
                    term_reg <= SUM_W'(quo * ({1'b0, wrd_reg} + 9'(WEIGHT_OFFSET)));
                else
                    term_reg <= SUM_W'(quo);
            end
            ST_V_ACC:
                vmem[caddr] <= acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
            ST_CLEAR, ST_INIT:
                vmem[caddr] <= '0;
            ST_M_RD:
                vrd_reg <= vmem[caddr];
            ST_M_CMP:
                if (vrd_reg > bestv_reg)
                begin
                    bestv_reg <= vrd_reg;
                    best_reg <= caddr;
                end
            ST_R_RD:
                vrd_reg <= vmem[caddr];
            default: ;
        endcase
        if (state_reg == ST_IDLE && in_valid && in_ready && command == CMD_WRITE)
            wmem[{pos_y, pos_x}] <= weight_value;
        if (state_reg == ST_OUT)
        begin
            case (cmd_reg)
                CMD_VOTE:
                begin
                    rx_reg <= '0; ry_reg <= '0; rs_reg <= '0; rsat_reg <= sat_reg;
                end
                CMD_MAX:
                begin
                    rx_reg <= best_reg[XW-1:0];
                    ry_reg <= best_reg[AW-1:XW];
                    rs_reg <= bestv_reg;
                    rsat_reg <= 1'b0;
                end
                CMD_READ:
                begin
                    rx_reg <= ox_reg; ry_reg <= oy_reg; rs_reg <= vrd_reg; rsat_reg <= 1'b0;
                end
                default:
                begin
                    rx_reg <= '0; ry_reg <= '0; rs_reg <= '0; rsat_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== tb/tb_gradient_center_vote_accumulator.sv =====
`timescale 1ns / 1ps

module tb_gradient_center_vote_accumulator;
    import gcva_pkg::*;

    localparam logic [2:0] CMD_SPARE5 = 3'd5;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;
    localparam int CELLS = MAP_WIDTH * MAP_HEIGHT;
    localparam int STALL_LIMIT = 60000;

    typedef struct {
        logic [2:0]         cmd;
        logic [5:0]         x;
        logic [5:0]         y;
        logic signed [15:0] gx;
        logic signed [15:0] gy;
        logic [7:0]         w;
    } beat_t;

    typedef struct {
        logic [5:0]       rx;
        logic [5:0]       ry;
        logic [SUM_W-1:0] sum;
        logic             sat;
    } result_t;

    typedef struct {
        beat_t   b;
        bit      fixed;
        result_t r;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [6:0]         cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         command;
    logic [5:0]         pos_x;
    logic [5:0]         pos_y;
    logic signed [15:0] grad_x;
    logic signed [15:0] grad_y;
    logic [7:0]         weight_value;
    logic               out_valid;
    logic               out_ready;
    logic [5:0]         result_x;
    logic [5:0]         result_y;
    logic [SUM_W-1:0]   vote_sum;
    logic               saturated;

    gradient_center_vote_accumulator dut (.*);

    // shadow state
    logic [SUM_W-1:0] votes [CELLS];
    logic [7:0]       weights [CELLS];
    int               a_left;
    int               a_top;
    int               a_w;
    int               a_h;
    bit               wen;

    result_t expected_q [$];
    row_t    dir_tbl [$];
    int      errors;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      idle_cycles;
    int      n_votes;
    int      n_reads;
    int      n_max;
    int      n_other;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic result_t apply_beat(beat_t b);
        result_t r;
        int xe;
        int ye;
        int best;
        int idx;
        longint dx;
        longint dy;
        longint dot;
        longint unsigned num;
        longint unsigned den;
        longint unsigned term;
        longint unsigned s;
        r = '{default: '0};
        idx = b.y * MAP_WIDTH + b.x;
        case (b.cmd)
            CMD_CLEAR: foreach (votes[i]) votes[i] = '0;
            CMD_WRITE: weights[idx] = b.w;
            CMD_VOTE:
            begin
                xe = (a_left + a_w > MAP_WIDTH) ? MAP_WIDTH : a_left + a_w;
                ye = (a_top + a_h > MAP_HEIGHT) ? MAP_HEIGHT : a_top + a_h;
                for (int cy = a_top; cy < ye; cy++)
                begin
                    for (int cx = a_left; cx < xe; cx++)
                    begin
                        dx = longint'(b.x) - cx;
                        dy = longint'(b.y) - cy;
                        if (dx == 0 && dy == 0)
                            continue;
                        dot = dx * longint'(b.gx) + dy * longint'(b.gy);
                        if (dot <= 0)
                            continue;
                        num = dot * dot;
                        den = longint'(dx * dx + dy * dy) << 12;
                        term = num / den;
                        if (wen)
                            term = term * (weights[cy * MAP_WIDTH + cx] + 5);
                        s = votes[cy * MAP_WIDTH + cx] + term;
                        if (s > SUM_MAX)
                        begin
                            s = SUM_MAX;
                            r.sat = 1'b1;
                        end
                        votes[cy * MAP_WIDTH + cx] = s[SUM_W-1:0];
                    end
                end
            end
            CMD_MAX:
            begin
                best = 0;
                for (int i = 1; i < CELLS; i++)
                    if (votes[i] > votes[best])
                        best = i;
                r.rx = 6'(best % MAP_WIDTH);
                r.ry = 6'(best / MAP_WIDTH);
                r.sum = votes[best];
            end
            CMD_READ:
            begin
                r.rx = b.x;
                r.ry = b.y;
                r.sum = votes[idx];
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        result_t e;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("unexpected beat", vote_sum, 0);
                else
                begin
                    e = expected_q.pop_front();
                    if (result_x !== e.rx) report_mismatch("result_x", result_x, e.rx);
                    if (result_y !== e.ry) report_mismatch("result_y", result_y, e.ry);
                    if (vote_sum !== e.sum) report_mismatch("vote_sum", vote_sum, e.sum);
                    if (saturated !== e.sat) report_mismatch("saturated", saturated, e.sat);
                end
            end
        end
    end

    task automatic write_reg(reg_idx_t idx, int v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v[6:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_LEFT:   a_left = v & 63;
            REG_TOP:    a_top = v & 63;
            REG_WIDTH:  a_w = v & 127;
            REG_HEIGHT: a_h = v & 127;
            REG_WEN:    wen = v[0];
            default: ;
        endcase
    endtask

    task automatic set_area(int l, int t, int w, int h, bit en);
        write_reg(REG_LEFT, l);
        write_reg(REG_TOP, t);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_WEN, en);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_beat(beat_t b, bit fixed, result_t fr);
        result_t p;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= b.cmd;
        pos_x        <= b.x;
        pos_y        <= b.y;
        grad_x       <= b.gx;
        grad_y       <= b.gy;
        weight_value <= b.w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        p = apply_beat(b);
        if (fixed)
            p = fr;
        expected_q = {expected_q, p};
        case (b.cmd)
            CMD_VOTE: n_votes++;
            CMD_READ: n_reads++;
            CMD_MAX:  n_max++;
            default:  n_other++;
        endcase
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic beat_t mk_beat(logic [2:0] c, int x, int y, int gx, int gy, int w);
        beat_t b;
        b.cmd = c;
        b.x = 6'(x);
        b.y = 6'(y);
        b.gx = 16'(gx);
        b.gy = 16'(gy);
        b.w = 8'(w);
        return b;
    endfunction

    function automatic void add_row(logic [2:0] c, int x, int y, int gx, int gy, int w);
        row_t r;
        r.b = mk_beat(c, x, y, gx, gy, w);
        r.fixed = 1'b0;
        r.r = '{default: '0};
        dir_tbl = {dir_tbl, r};
    endfunction

    function automatic void add_fixed(logic [2:0] c, int x, int y, int gx, int gy, int w,
                                      int rx, int ry, longint unsigned s);
        row_t r;
        r.b = mk_beat(c, x, y, gx, gy, w);
        r.fixed = 1'b1;
        r.r.rx = 6'(rx);
        r.r.ry = 6'(ry);
        r.r.sum = SUM_W'(s);
        r.r.sat = 1'b0;
        dir_tbl = {dir_tbl, r};
    endfunction

    function automatic beat_t random_beat();
        beat_t b;
        int pick;
        int lo;
        int hi;
        b.cmd = 3'($urandom_range(7));
        b.x = 6'($urandom);
        b.y = 6'($urandom);
        b.gx = 16'($urandom);
        b.gy = 16'($urandom);
        b.w = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            b.cmd = CMD_VOTE;
            if ($urandom_range(99) < 70)
            begin
                lo = (a_left > 2) ? a_left - 2 : 0;
                hi = (a_left + a_w + 1 > 63) ? 63 : a_left + a_w + 1;
                b.x = 6'($urandom_range(hi, lo));
                lo = (a_top > 2) ? a_top - 2 : 0;
                hi = (a_top + a_h + 1 > 63) ? 63 : a_top + a_h + 1;
                b.y = 6'($urandom_range(hi, lo));
            end
            if ($urandom_range(99) < 80)
            begin
                b.gx = 16'(int'($urandom_range(32768)) - 16384);
                b.gy = 16'(int'($urandom_range(32768)) - 16384);
            end
        end
        else if (pick < 75)
            b.cmd = CMD_READ;
        else if (pick < 85)
            b.cmd = CMD_WRITE;
        else if (pick < 92)
            b.cmd = CMD_MAX;
        else if (pick < 95)
            b.cmd = CMD_CLEAR;
        else
            b.cmd = $urandom_range(1) ? CMD_SPARE5 : CMD_SPARE7;
        return b;
    endfunction

    initial
    begin
        result_t none;
        int al;
        int at;
        none = '{default: '0};
        errors = 0;
        n_votes = 0;
        n_reads = 0;
        n_max = 0;
        n_other = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        command = '0;
        pos_x = '0;
        pos_y = '0;
        grad_x = '0;
        grad_y = '0;
        weight_value = '0;
        foreach (votes[i]) votes[i] = '0;
        foreach (weights[i]) weights[i] = '0;
        a_left = 0;
        a_top = 0;
        a_w = 64;
        a_h = 64;
        wen = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_area(30, 30, 4, 4, 1'b1);

        // weighted areas stay inside this 4x4 patch, written before any vote
        for (int i = 0; i < 16; i++)
            send_beat(mk_beat(CMD_WRITE, 30 + i % 4, 30 + i / 4, 0, 0, $urandom), 1'b1,
                      none);
        drain();

        add_fixed(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        add_fixed(CMD_READ, 63, 63, -1, -1, 255, 63, 63, 0);
        add_fixed(CMD_MAX, 0, 0, 0, 0, 0, 0, 0, 0);
        add_fixed(CMD_SPARE5, 63, 63, -32768, 32767, 255, 0, 0, 0);
        add_fixed(CMD_SPARE7, 21, 42, 12345, -12345, 170, 0, 0, 0);
        add_fixed(CMD_WRITE, 63, 63, 0, 0, 255, 0, 0, 0);
        add_fixed(CMD_WRITE, 0, 0, 0, 0, 0, 0, 0, 0);
        add_fixed(CMD_WRITE, 30, 30, 0, 0, 255, 0, 0, 0);
        add_row(CMD_VOTE, 30, 30, 16384, 0, 0);
        add_row(CMD_VOTE, 32, 32, 0, -16384, 0);
        add_row(CMD_VOTE, 0, 0, -32768, -32768, 0);
        add_row(CMD_VOTE, 63, 63, 32767, 32767, 0);
        add_row(CMD_VOTE, 63, 0, 16384, -16384, 0);
        add_row(CMD_VOTE, 31, 31, 0, 0, 0);
        add_row(CMD_VOTE, 28, 35, -32768, 16384, 0);
        add_row(CMD_MAX, 0, 0, 0, 0, 0);
        add_row(CMD_READ, 30, 30, 0, 0, 0);
        add_row(CMD_READ, 28, 28, 0, 0, 0);
        add_row(CMD_READ, 33, 33, 0, 0, 0);
        add_fixed(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
        add_fixed(CMD_MAX, 0, 0, 0, 0, 0, 0, 0, 0);
        add_fixed(CMD_READ, 35, 35, 0, 0, 0, 35, 35, 0);

        send_idle_pct = 33;
        recv_stall_pct = 84;
        foreach (dir_tbl[i])
            send_beat(dir_tbl[i].b, dir_tbl[i].fixed, dir_tbl[i].r);
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct  = (ph == 0) ? 33 : (ph == 1) ? 84 : 0;
            recv_stall_pct = (ph == 0) ? 84 : (ph == 1) ? 33 : 0;
            for (int blk = 0; blk < 4; blk++)
            begin
                case (blk)
                    0:
                    begin
                        al = 30 + $urandom_range(3);
                        at = 30 + $urandom_range(3);
                        set_area(al, at, $urandom_range(34 - al, 1),
                                 $urandom_range(34 - at, 1), 1'b1);
                    end
                    1: set_area($urandom_range(58), $urandom_range(58),
                                $urandom_range(6, 1), $urandom_range(6, 1), 1'b0);
                    2: set_area(ph == 1 ? 60 : 63, $urandom_range(63, 58), 64, 64, 1'b0);
                    default: set_area($urandom_range(63), $urandom_range(63),
                                      ph == 2 ? 5 : 0, ph == 2 ? 0 : 5, 1'b1);
                endcase
                repeat (8)
                    send_beat(random_beat(), 1'b0, none);
                drain();
            end
        end

        $display("covered %0d votes, %0d reads, %0d max reports, %0d other beats",
                 n_votes, n_reads, n_max, n_other);
        $display("area settings: small weighted, unweighted, clipped at map edge, empty");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== gradient_center_vote_accumulator.f =====
design/gcva_pkg.sv
design/gcva_div.sv
design/gradient_center_vote_accumulator.sv
tb/tb_gradient_center_vote_accumulator.sv
